// File: src/ptm_pkg.sv
// Package for the pad trigger mode block: mode, status and register index
// codes, the per-pad mark bundle, the result and configuration bundles and the field widths.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ptm_pkg;

   localparam int PressureWidth = 10;
   localparam int ModeWidth     = 3;
   localparam int StatusWidth   = 2;
   localparam int CsrAddrWidth  = 1;
   localparam int CsrDataWidth  = 10;
   localparam int ReqDataWidth  = 16;
   localparam int RspDataWidth  = 8;

   localparam logic [PressureWidth-1:0] FullLevelReset = 10'd511;

   typedef enum logic [ModeWidth-1:0] {
      MODE_HOLD       = 3'd0,
      MODE_TOGGLE     = 3'd1,
      MODE_LATCH      = 3'd2,
      MODE_TRIGGER    = 3'd3,
      MODE_CYCLE      = 3'd4,
      MODE_AUTO_CYCLE = 3'd5
   } mode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_STOP     = 2'd0,
      ST_START    = 2'd1,
      ST_NOCHANGE = 2'd2
   } status_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_TRIGGER_MODE = 1'b0,
      CSR_FULL_LEVEL   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic playing;
      logic pressed_mark;
      logic released_mark;
      logic max_pending;
      logic repress_mark;
      logic advance_flag;
   } marks_type;

   typedef struct packed {
      status_type play_status;
      logic       move_next;
      logic       ignore_pressure;
   } result_type;

   typedef struct packed {
      logic [ModeWidth-1:0]     trigger_mode;
      logic [PressureWidth-1:0] full_level;
   } csr_type;

endpackage

// File: src/ptm_csr.sv
// Configuration registers of the pad trigger mode block: trigger mode and
// full-press pressure level. Depends on ptm_pkg.
`timescale 1ns / 1ps

module ptm_csr
   import ptm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output csr_type                 csr
);

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_TRIGGER_MODE: csr_in.trigger_mode = csr_wdata[ModeWidth-1:0];
            CSR_FULL_LEVEL:   csr_in.full_level   = csr_wdata[PressureWidth-1:0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.trigger_mode <= ModeWidth'(MODE_HOLD);
         csr_ff.full_level   <= FullLevelReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// File: src/ptm_rules.sv
// Combinational rule sets of the pad trigger modes: from the current marks,
// one sample and the configuration, the next marks and the result.
// Depends on ptm_pkg.
`timescale 1ns / 1ps

module ptm_rules
   import ptm_pkg::*;
(
   input  marks_type                marks,
   input  csr_type                  csr,
   input  logic [PressureWidth-1:0] pad_pressure,
   input  logic                     clear,
   output marks_type                marks_next,
   output result_type               result
);

   logic down;
   logic full;

   assign down = (pad_pressure != '0);
   assign full = (pad_pressure == csr.full_level);

   always_comb begin
      marks_next             = marks;
      result.play_status     = ST_NOCHANGE;
      result.ignore_pressure = 1'b0;
      result.move_next       = 1'b0;

      case (mode_type'(csr.trigger_mode))
         MODE_HOLD: begin
            if (!marks.playing && down) begin
               result.play_status       = ST_START;
               marks_next.playing       = 1'b1;
               marks_next.pressed_mark  = 1'b1;
               marks_next.released_mark = 1'b1;
            end else if (marks.playing && !down) begin
               result.play_status       = ST_STOP;
               marks_next.playing       = 1'b0;
               marks_next.pressed_mark  = 1'b0;
               marks_next.released_mark = 1'b0;
            end
            marks_next.repress_mark = 1'b0;
            marks_next.max_pending  = 1'b1;
            marks_next.advance_flag = 1'b0;
         end
         MODE_TOGGLE, MODE_AUTO_CYCLE: begin
            if (!marks.playing && down && !marks.pressed_mark && !marks.released_mark) begin
               result.play_status      = ST_START;
               marks_next.playing      = 1'b1;
               marks_next.pressed_mark = 1'b1;
            end else if (marks.playing && !down) begin
               marks_next.released_mark = 1'b1;
            end else if (marks.playing && down && marks.released_mark
                         && marks.pressed_mark) begin
               result.play_status      = ST_STOP;
               marks_next.playing      = 1'b0;
               marks_next.pressed_mark = 1'b0;
            end else if (!marks.playing && !down && marks.released_mark
                         && !marks.pressed_mark) begin
               marks_next.released_mark = 1'b0;
            end
            marks_next.max_pending  = 1'b1;
            marks_next.repress_mark = 1'b0;
            marks_next.advance_flag = 1'b0;
            result.ignore_pressure  = (mode_type'(csr.trigger_mode) == MODE_AUTO_CYCLE);
         end
         MODE_LATCH: begin
            if (!marks.playing && down && !marks.pressed_mark && !marks.released_mark) begin
               result.play_status      = ST_START;
               marks_next.playing      = 1'b1;
               marks_next.pressed_mark = 1'b1;
               marks_next.max_pending  = 1'b1;
            end else if (full && marks.max_pending) begin
               marks_next.max_pending = 1'b0;
            end else if (marks.playing && !down && !marks.max_pending) begin
               result.play_status       = ST_STOP;
               marks_next.playing       = 1'b0;
               marks_next.released_mark = 1'b0;
               marks_next.pressed_mark  = 1'b0;
            end else if (marks.playing && !down && marks.pressed_mark) begin
               marks_next.released_mark = 1'b1;
            end
            marks_next.repress_mark = 1'b0;
            marks_next.advance_flag = 1'b0;
         end
         MODE_TRIGGER: begin
            if (down && !marks.repress_mark) begin
               result.play_status      = ST_START;
               marks_next.playing      = 1'b1;
               marks_next.pressed_mark = 1'b1;
               marks_next.repress_mark = 1'b1;
               marks_next.max_pending  = 1'b1;
            end else if (marks.playing && !down && marks.pressed_mark
                         && marks.max_pending) begin
               marks_next.released_mark = 1'b1;
               marks_next.repress_mark  = 1'b0;
            end else if (full) begin
               marks_next.max_pending = 1'b0;
            end else if (marks.playing && !down && !marks.max_pending) begin
               result.play_status       = ST_STOP;
               marks_next.playing       = 1'b0;
               marks_next.pressed_mark  = 1'b0;
               marks_next.released_mark = 1'b0;
               marks_next.repress_mark  = 1'b0;
            end
            marks_next.advance_flag = 1'b0;
         end
         MODE_CYCLE: begin
            if (!marks.playing && down && !marks.pressed_mark) begin
               result.play_status      = ST_START;
               marks_next.playing      = 1'b1;
               marks_next.pressed_mark = 1'b1;
               marks_next.repress_mark = 1'b1;
               marks_next.max_pending  = 1'b1;
            end else if (marks.playing && !down && marks.pressed_mark
                         && marks.max_pending) begin
               marks_next.released_mark = 1'b1;
               marks_next.repress_mark  = 1'b0;
            end else if (marks.playing && down && !marks.repress_mark
                         && marks.released_mark) begin
               marks_next.advance_flag = 1'b1;
               marks_next.repress_mark = 1'b1;
            end else if (full) begin
               marks_next.max_pending = 1'b0;
            end else if (marks.playing && !down && !marks.max_pending) begin
               result.play_status       = ST_STOP;
               marks_next.playing       = 1'b0;
               marks_next.pressed_mark  = 1'b0;
               marks_next.released_mark = 1'b0;
               marks_next.repress_mark  = 1'b0;
            end else begin
               marks_next.advance_flag = 1'b0;
            end
            result.ignore_pressure = 1'b1;
         end
         default: begin
            // Undefined mode codes leave the marks alone but drop the advance.
            marks_next.advance_flag = 1'b0;
         end
      endcase

      result.move_next = marks_next.advance_flag;

      // A clear event wins over every mode.
      if (clear) begin
         marks_next             = '0;
         result.play_status     = ST_STOP;
         result.move_next       = 1'b0;
         result.ignore_pressure = 1'b0;
      end
   end

endmodule

// File: src/pad_trigger_mode_fsm.sv
// An accepted item waits in the input register; it is evaluated by the rule
// logic and written to the result register once that register is empty or its
// result is being taken, and is shown on the result channel from then on.
// Throughput: one item per cycle unless the result channel stalls, set by the
// combinational rule logic between the two registers; marks update once per item.
// Reset is synchronous and active high: it empties both stages, zeroes all
// pad marks and loads trigger mode hold with a full-press level of 511.
`timescale 1ns / 1ps

module pad_trigger_mode_fsm
   import ptm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   // Configuration write port; index 0 is trigger_mode, 1 is the full-press level.
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata,

   // Input channel.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,  // [9:0] pad_pressure, upper bits zero
   input  logic                    req_tuser,  // [0] clear

   // Result channel.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata   // [1:0] play_status, [2] move_next,
                                               // [3] ignore_pressure, upper bits zero
);

   // Configuration registers live in their own small unit.
   csr_type csr;

   ptm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   // Input stage. It holds one item; it hands it on whenever the result
   // register is empty or its current result is being taken, so a waiting
   // result does not stop a new item from coming in behind it.
   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [PressureWidth-1:0] in_pressure_ff;
   logic                     in_clear_ff;
   logic                     advance;
   logic                     req_take;

   logic                     out_valid_ff;
   logic                     out_valid_in;
   result_type               out_result_ff;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pressure_ff <= req_tdata[PressureWidth-1:0];
         in_clear_ff    <= req_tuser;
      end
   end

   // Pad marks. They change only when an item moves from the input stage
   // into the result register, which keeps results in item order.
   marks_type  marks_ff;
   marks_type  marks_in;
   marks_type  marks_next;
   result_type result_next;

   ptm_rules u_rules (
      .marks        (marks_ff),
      .csr          (csr),
      .pad_pressure (in_pressure_ff),
      .clear        (in_clear_ff),
      .marks_next   (marks_next),
      .result       (result_next)
   );

   assign marks_in = advance ? marks_next : marks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
      end else begin
         marks_ff <= marks_in;
      end
   end

   // Result register. It fills on a hand-off and empties when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RspDataWidth'({out_result_ff.ignore_pressure,
                                      out_result_ff.move_next,
                                      out_result_ff.play_status});

endmodule

// File: src/ptm_checker.sv
// Port-level checks for the pad trigger mode block, bound to its top level.
// Depends on ptm_pkg and pad_trigger_mode_fsm.
`timescale 1ns / 1ps

module ptm_checker
   import ptm_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // With no result waiting, the block always takes an item.
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled while result register empty");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Status never goes above the no-change code, and advance only comes in
   // cycle mode, which always marks pressure as ignored.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] <= StatusWidth'(ST_NOCHANGE))
                     && (!rsp_tdata[2] || rsp_tdata[3]))
      else $error("inconsistent result fields");

endmodule

bind pad_trigger_mode_fsm ptm_checker u_ptm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
